FILE: design/jsfx_pkg.sv
// ---------------------------------------------------------------------------
// jsfx_pkg
// Shared types, character codes and helper functions for the JSON string
// field extractor.
// ---------------------------------------------------------------------------
package jsfx_pkg;

  localparam int unsigned MAX_NAME_BYTES = 8;

  // configuration register indexes
  localparam logic CFG_FIELD_NAME = 1'b0;
  localparam logic CFG_NAME_LEN   = 1'b1;

  // reset contents: "content", seven bytes
  localparam logic [63:0] FIELD_NAME_RST = 64'd32772479322582883;
  localparam logic [3:0]  NAME_LEN_RST   = 4'd7;

  // ASCII codes
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_U      = 8'h75;

  // one result beat
  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       status;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] b;   // b[0] goes out first
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // UTF-8 of a 16-bit code; surrogates give nothing
  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 16'h0080) begin
      u.cnt  = 2'd1;
      u.b[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      u.cnt  = 2'd2;
      u.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      u.b[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < 16'hD800 || cp > 16'hDFFF) begin
      u.cnt  = 2'd3;
      u.b[0] = 8'hE0 | {4'h0, cp[15:12]};
      u.b[1] = 8'h80 | {2'b00, cp[11:6]};
      u.b[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return u;
  endfunction

endpackage

FILE: design/jsfx_key_window.sv
// ---------------------------------------------------------------------------
// jsfx_key_window
// Recent-byte history and quoted key compare for the field extractor.
// ---------------------------------------------------------------------------
module jsfx_key_window #(
  parameter int unsigned MAX_NAME_BYTES = jsfx_pkg::MAX_NAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic        clear_i,
  input  logic [7:0]  byte_i,
  input  logic [63:0] name_i,
  input  logic [3:0]  name_len_i,
  output logic        match_o
);

  localparam int unsigned Depth = MAX_NAME_BYTES + 2;
  localparam int unsigned IdxW  = $clog2(MAX_NAME_BYTES + 1);
  localparam logic [3:0]  MaxLen = 4'(MAX_NAME_BYTES);

  logic [7:0] win_q [Depth];
  logic [7:0] win_n [Depth];   // window after this byte is shifted in
  logic [MAX_NAME_BYTES:0] ok_len;
  logic [3:0] len_sat;

  always_comb begin
    win_n[0] = byte_i;
    for (int k = 1; k < Depth; k++) begin
      win_n[k] = win_q[k-1];
    end
  end

  // one candidate match per possible key length
  always_comb begin
    for (int l = 0; l <= MAX_NAME_BYTES; l++) begin
      ok_len[l] = (win_n[0] == jsfx_pkg::CHR_QUOTE) &&
                  (win_n[l+1] == jsfx_pkg::CHR_QUOTE);
      for (int k = 1; k <= l; k++) begin
        if (win_n[k] != name_i[8*(l-k) +: 8]) begin
          ok_len[l] = 1'b0;
        end
      end
    end
  end

  assign len_sat = (name_len_i > MaxLen) ? MaxLen : name_len_i;
  assign match_o = ok_len[len_sat[IdxW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) begin
        win_q[k] <= '0;
      end
    end else if (clear_i) begin
      for (int k = 0; k < Depth; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < Depth; k++) begin
        win_q[k] <= win_n[k];
      end
    end
  end

endmodule

FILE: design/json_string_field_extractor.sv
// ---------------------------------------------------------------------------
// json_string_field_extractor
// Finds a quoted key in a JSON body and streams its unescaped string value.
// ---------------------------------------------------------------------------
// Takes one body byte per beat (end_of_body_i on the final byte), finds the
// first "<field_name>" key, skips to the colon and any spaces or line feeds,
// then streams the string value one decoded byte per output beat: \n \r \t \"
// and \\ are decoded, other escapes pass the escaped byte, and \uXXXX becomes
// 1..3 bytes of UTF-8 (surrogate codes give nothing). Each body ends with
// exactly one status beat (kind_o = 1): status_o = 0 when the string closed,
// 1 when the body ended first, a non-quote followed the colon, or \u had no
// hex digit. run_end_o flags the last output beat caused by one input beat.
// Rate: one input beat per clock unless stalled. Each beat is decoded into a
// burst of 0..4 result beats held in a four-entry output buffer, which drains
// one beat per clock while out_stall_i is low; the input is taken whenever
// that buffer is empty or its last beat is leaving, so a beat with k > 1
// results holds the input until the rest have left. There is no clearing pass
// after reset. field_name / field_name_length may only be written while idle.
module json_string_field_extractor #(
  parameter int unsigned MAX_NAME_BYTES = jsfx_pkg::MAX_NAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_body_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic        status_o,
  output logic        run_end_o
);

  // parser phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_SPACE  = 3'd2;
  localparam logic [2:0] PH_STRING = 3'd3;
  localparam logic [2:0] PH_ESCAPE = 3'd4;
  localparam logic [2:0] PH_HEX    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam int unsigned NumRes = 4;

  // config registers
  logic [63:0] name_q;
  logic [3:0]  name_len_q;

  // parser state
  logic [2:0]  phase_q, phase_d;
  logic [15:0] cp_q, cp_d;
  logic [1:0]  pos_q, pos_d;     // hex byte count within \uXXXX
  logic        stop_q, stop_d;   // hex run already hit a non-hex byte

  // output burst buffer, entry 0 is on the port
  jsfx_pkg::res_t slot_q [NumRes];
  jsfx_pkg::res_t slot_d [NumRes];
  logic [2:0]     cnt_q, cnt_d;

  logic in_acc, out_acc;
  logic key_hit;

  // decoded results for the current beat
  logic [1:0]      dat_cnt;
  logic [2:0][7:0] dat;
  logic            st_en, st_val;
  jsfx_pkg::res_t  res [NumRes];
  logic [2:0]      res_cnt;

  jsfx_pkg::hex_t  hx;
  jsfx_pkg::utf8_t u8;
  logic [15:0]     cp_new;

  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == '0) || ((cnt_q == 3'd1) && !out_stall_i));
  assign in_acc      = in_valid_i && !in_stall_o;

  assign kind_o     = slot_q[0].kind;
  assign out_byte_o = slot_q[0].out_byte;
  assign status_o   = slot_q[0].status;
  assign run_end_o  = (cnt_q == 3'd1);

  jsfx_key_window #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_key_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (in_acc && (phase_q == PH_SEARCH)),
    .clear_i    (in_acc && end_of_body_i),
    .byte_i     (data_byte_i),
    .name_i     (name_q),
    .name_len_i (name_len_q),
    .match_o    (key_hit)
  );

  // hex accumulate and UTF-8 of the updated code
  assign hx     = jsfx_pkg::hex_value(data_byte_i);
  assign cp_new = (!stop_q && hx.ok) ? {cp_q[11:0], hx.val} : cp_q;
  assign u8     = jsfx_pkg::utf8_encode(cp_new);

  // per-beat parse step
  always_comb begin
    phase_d = phase_q;
    cp_d    = cp_q;
    pos_d   = pos_q;
    stop_d  = stop_q;
    dat_cnt = '0;
    dat     = '0;
    st_en   = 1'b0;
    st_val  = 1'b0;

    case (phase_q)
      PH_SEARCH: begin
        if (key_hit) begin
          phase_d = PH_COLON;
        end
      end
      PH_COLON: begin
        if (data_byte_i == jsfx_pkg::CHR_COLON) begin
          phase_d = PH_SPACE;
        end
      end
      PH_SPACE: begin
        if (data_byte_i == jsfx_pkg::CHR_QUOTE) begin
          phase_d = PH_STRING;
        end else if (data_byte_i != jsfx_pkg::CHR_SPACE &&
                     data_byte_i != jsfx_pkg::CHR_LF) begin
          st_en   = 1'b1;
          st_val  = 1'b1;
          phase_d = PH_DONE;
        end
      end
      PH_STRING: begin
        if (data_byte_i == jsfx_pkg::CHR_QUOTE) begin
          st_en   = 1'b1;
          phase_d = PH_DONE;
        end else if (data_byte_i == jsfx_pkg::CHR_BSLASH) begin
          phase_d = PH_ESCAPE;
        end else begin
          dat_cnt = 2'd1;
          dat[0]  = data_byte_i;
        end
      end
      PH_ESCAPE: begin
        phase_d = PH_STRING;
        dat_cnt = 2'd1;
        case (data_byte_i)
          jsfx_pkg::CHR_N: dat[0] = jsfx_pkg::CHR_LF;
          jsfx_pkg::CHR_R: dat[0] = jsfx_pkg::CHR_CR;
          jsfx_pkg::CHR_T: dat[0] = jsfx_pkg::CHR_TAB;
          jsfx_pkg::CHR_U: begin
            dat_cnt = '0;
            phase_d = PH_HEX;
            cp_d    = '0;
            pos_d   = '0;
            stop_d  = 1'b0;
          end
          default: dat[0] = data_byte_i;
        endcase
      end
      PH_HEX: begin
        cp_d   = cp_new;
        stop_d = stop_q || !hx.ok;
        if ((pos_q == '0) && !hx.ok) begin
          // no hex digit at all after \u
          st_en   = 1'b1;
          st_val  = 1'b1;
          phase_d = PH_DONE;
        end else begin
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            dat_cnt = u8.cnt;
            dat     = u8.b;
            phase_d = PH_STRING;
          end
        end
      end
      PH_DONE: begin
        // rest of the body is ignored
      end
      default: begin
        phase_d = PH_SEARCH;
      end
    endcase

    // end of body: status if none yet, then start over
    if (end_of_body_i) begin
      if (phase_d != PH_DONE) begin
        st_en  = 1'b1;
        st_val = 1'b1;
      end
      phase_d = PH_SEARCH;
      pos_d   = '0;
    end
  end

  // pack data bytes then the optional status into burst order
  always_comb begin
    for (int i = 0; i < NumRes; i++) begin
      res[i] = '0;
      if (i < 32'(dat_cnt)) begin
        res[i].out_byte = dat[i];
      end else if ((i == 32'(dat_cnt)) && st_en) begin
        res[i].kind   = 1'b1;
        res[i].status = st_val;
      end
    end
    res_cnt = {1'b0, dat_cnt} + {2'b00, st_en};
  end

  // output buffer: load a fresh burst or shift one beat out
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < NumRes; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (in_acc) begin
      cnt_d = res_cnt;
      for (int i = 0; i < NumRes; i++) begin
        slot_d[i] = res[i];
      end
    end else if (out_acc) begin
      cnt_d = cnt_q - 3'd1;
      for (int i = 0; i < NumRes - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q     <= jsfx_pkg::FIELD_NAME_RST;
      name_len_q <= jsfx_pkg::NAME_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == jsfx_pkg::CFG_FIELD_NAME) begin
        name_q <= cfg_data_i;
      end else begin
        name_len_q <= cfg_data_i[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      cp_q    <= '0;
      pos_q   <= '0;
      stop_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        phase_q <= phase_d;
        cp_q    <= cp_d;
        pos_q   <= pos_d;
        stop_q  <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumRes; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

`ifndef SYNTHESIS
  // a status beat always closes its burst
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> run_end_o)
    else $error("status beat is not the last of its burst");

  // the last byte of a body always rearms the key search
  a_body_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_body_i) |=> (phase_q == PH_SEARCH))
    else $error("parser not back in search after end of body");

  // hex position only moves inside a \u escape
  a_hex_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEX) |-> (pos_q == '0))
    else $error("hex position set outside of a \\u escape");

  // burst buffer never holds more than one beat's worth of results
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(NumRes))
    else $error("result buffer count out of range");
`endif

endmodule
